FILE: src/ucrh_pkg.sv
// Package for the USB control request handler.
// Holds codes, reset values, limits and the request/command record types.
// No dependencies; every other file refers to it by scoped names.
package ucrh_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [16:0] MAX_TRANSFER = 17'd4096;

	// Event kinds.
	localparam logic [1:0] KIND_SETUP    = 2'd0;
	localparam logic [1:0] KIND_BUS_RST  = 2'd1;
	localparam logic [1:0] KIND_CONSUMED = 2'd2;

	// Request type field, bits 6:5 of bmRequestType.
	localparam logic [1:0] RTYPE_STD   = 2'd0;
	localparam logic [1:0] RTYPE_CLASS = 2'd1;

	// Standard request codes.
	localparam logic [7:0] STD_GET_STATUS        = 8'd0;
	localparam logic [7:0] STD_CLEAR_FEATURE     = 8'd1;
	localparam logic [7:0] STD_SET_FEATURE       = 8'd3;
	localparam logic [7:0] STD_SET_ADDRESS       = 8'd5;
	localparam logic [7:0] STD_GET_DESCRIPTOR    = 8'd6;
	localparam logic [7:0] STD_SET_DESCRIPTOR    = 8'd7;
	localparam logic [7:0] STD_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] STD_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] STD_GET_INTERFACE     = 8'd10;
	localparam logic [7:0] STD_SET_INTERFACE     = 8'd11;
	localparam logic [7:0] STD_SYNC_FRAME        = 8'd12;

	// Class request codes.
	localparam logic [7:0] REQ_SET_REPORT = 8'd9;
	localparam logic [7:0] REQ_SET_IDLE   = 8'd10;

	// Descriptor types.
	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_STRING = 8'h03;
	localparam logic [7:0] DESC_REPORT = 8'h22;

	// Device states.
	localparam logic [2:0] ST_ATTACHED   = 3'd1;
	localparam logic [2:0] ST_DEFAULT    = 3'd2;
	localparam logic [2:0] ST_ADDRESS    = 3'd3;
	localparam logic [2:0] ST_CONFIGURED = 3'd4;

	// Pending operations.
	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_RECEIVE = 2'd1;
	localparam logic [1:0] OP_INIT    = 2'd3;

	// Buffer selects.
	localparam logic [2:0] BUF_IN     = 3'd0;
	localparam logic [2:0] BUF_OUT    = 3'd1;
	localparam logic [2:0] BUF_DEV    = 3'd2;
	localparam logic [2:0] BUF_CFG    = 3'd3;
	localparam logic [2:0] BUF_STR0   = 3'd4;
	localparam logic [2:0] BUF_MAN    = 3'd5;
	localparam logic [2:0] BUF_PROD   = 3'd6;
	localparam logic [2:0] BUF_REPORT = 3'd7;

	localparam logic [16:0] LEN_OUT_STAGE = 17'h40;
	localparam logic [16:0] LEN_EP1_OUT   = 17'h80;
	localparam logic [16:0] LEN_REPORT_HDR = 17'd64;

	// Configuration register indexes and reset values.
	localparam logic [2:0] REG_DEV_LEN    = 3'd0;
	localparam logic [2:0] REG_STR0_LEN   = 3'd1;
	localparam logic [2:0] REG_MAN_LEN    = 3'd2;
	localparam logic [2:0] REG_PROD_LEN   = 3'd3;
	localparam logic [2:0] REG_REPORT_LEN = 3'd4;

	localparam logic [7:0]  RST_DEV_LEN    = 8'd18;
	localparam logic [7:0]  RST_STR0_LEN   = 8'd4;
	localparam logic [7:0]  RST_MAN_LEN    = 8'd56;
	localparam logic [7:0]  RST_PROD_LEN   = 8'd28;
	localparam logic [11:0] RST_REPORT_LEN = 12'd76;

	typedef struct packed {
		logic        valid;
		logic        ep;
		logic [2:0]  buf_sel;
		logic        dir_in;
		logic [16:0] len;
		logic        cfg;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       n;
		cmd_t [2:0]       cmd;
		logic [2:0]       state;
		logic [6:0]       addr;
		logic [1:0]       op;
		logic [15:0]      rep;
	} job_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        too_long;
		logic [2:0]  state;
		logic [6:0]  addr;
		logic [1:0]  op;
		logic [15:0] rep;
		logic        last;
	} res_t;

endpackage

FILE: src/ucrh_front.sv
// Front end of the USB control request handler: configuration registers,
// device state and request decoding into a command list per request.
// Depends on ucrh_pkg.
module ucrh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          event_kind,
	input  logic [7:0]          request_type_byte,
	input  logic [7:0]          request_code,
	input  logic [15:0]         request_value,
	input  logic [15:0]         request_index,
	input  logic [15:0]         request_length,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [11:0]         cfg_data,
	input  logic                q_full,
	output logic                push,
	output ucrh_pkg::job_t      job
);

	logic [7:0]  dev_len_q, str0_len_q, man_len_q, prod_len_q;
	logic [11:0] report_len_q;
	logic [2:0]  state_q, state_d;
	logic [6:0]  addr_q, addr_d;
	logic [1:0]  op_q, op_d;
	logic [15:0] rl_q, rl_d;
	logic [1:0]  n;
	ucrh_pkg::cmd_t [2:0] cmds;
	ucrh_pkg::cmd_t c_ack, c_out_stage;
	logic [1:0]  rtype;
	logic [7:0]  dtype, dindex;
	logic [16:0] len17;
	logic        consumed;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign rtype    = request_type_byte[6:5];
	assign dtype    = request_value[15:8];
	assign dindex   = request_value[7:0];
	assign len17    = {1'b0, request_length};

	always_comb begin
		c_ack       = '{valid: 1'b1, ep: 1'b0, buf_sel: ucrh_pkg::BUF_IN, dir_in: 1'b1,
			len: 17'd0, cfg: 1'b0};
		c_out_stage = '{valid: 1'b1, ep: 1'b0, buf_sel: ucrh_pkg::BUF_OUT, dir_in: 1'b0,
			len: ucrh_pkg::LEN_OUT_STAGE, cfg: 1'b0};
	end

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		op_d     = op_q;
		rl_d     = rl_q;
		cmds     = '0;
		n        = 2'd0;
		consumed = 1'b0;
		unique case (event_kind)
			ucrh_pkg::KIND_SETUP: begin
				if (rtype == ucrh_pkg::RTYPE_STD) begin
					unique case (request_code) inside
						ucrh_pkg::STD_SET_ADDRESS: begin
							if (request_value != 16'd0) begin
								state_d = ucrh_pkg::ST_ADDRESS;
								addr_d  = request_value[6:0];
								op_d    = ucrh_pkg::OP_INIT;
								cmds[0] = c_ack;
								n       = 2'd1;
							end else if (state_q != ucrh_pkg::ST_CONFIGURED) begin
								state_d = ucrh_pkg::ST_DEFAULT;
							end
						end
						ucrh_pkg::STD_SET_CONFIGURATION: begin
							if (state_q == ucrh_pkg::ST_ADDRESS) begin
								state_d = ucrh_pkg::ST_CONFIGURED;
								cmds[0] = c_ack;
								n       = 2'd1;
							end
						end
						ucrh_pkg::STD_GET_DESCRIPTOR: begin
							cmds[0].valid  = 1'b1;
							cmds[0].dir_in = 1'b1;
							n              = 2'd1;
							if (dtype == ucrh_pkg::DESC_DEVICE) begin
								cmds[0].buf_sel = ucrh_pkg::BUF_DEV;
								cmds[0].len     = {9'd0, dev_len_q};
							end else if (dtype == ucrh_pkg::DESC_CONFIG) begin
								cmds[0].buf_sel = ucrh_pkg::BUF_CFG;
								cmds[0].len     = len17;
							end else if (dtype == ucrh_pkg::DESC_STRING && dindex == 8'd0) begin
								cmds[0].buf_sel = ucrh_pkg::BUF_STR0;
								cmds[0].len     = ({9'd0, str0_len_q} < len17) ?
									{9'd0, str0_len_q} : len17;
							end else if (dtype == ucrh_pkg::DESC_STRING && dindex == 8'd1) begin
								cmds[0].buf_sel = ucrh_pkg::BUF_MAN;
								cmds[0].len     = ({9'd0, man_len_q} < len17) ?
									{9'd0, man_len_q} : len17;
							end else if (dtype == ucrh_pkg::DESC_STRING && dindex == 8'd2) begin
								cmds[0].buf_sel = ucrh_pkg::BUF_PROD;
								cmds[0].len     = ({9'd0, prod_len_q} < len17) ?
									{9'd0, prod_len_q} : len17;
							end else if (dtype == ucrh_pkg::DESC_REPORT) begin
								cmds[0].buf_sel = ucrh_pkg::BUF_REPORT;
								cmds[0].len     = {5'd0, report_len_q};
							end else begin
								n = 2'd0;
							end
							if (n == 2'd1) begin
								cmds[1] = c_out_stage;
								n       = 2'd2;
							end else begin
								cmds[0] = c_out_stage;
								n       = 2'd1;
							end
						end
						ucrh_pkg::STD_GET_STATUS, ucrh_pkg::STD_CLEAR_FEATURE,
						ucrh_pkg::STD_SET_FEATURE, ucrh_pkg::STD_SET_DESCRIPTOR,
						ucrh_pkg::STD_GET_INTERFACE, ucrh_pkg::STD_SET_INTERFACE,
						ucrh_pkg::STD_SYNC_FRAME: begin
						end
						ucrh_pkg::STD_GET_CONFIGURATION: begin
							if (request_value == 16'd0 && request_index == 16'd0 &&
								request_length == 16'd1) begin
								cmds[0] = '{valid: 1'b1, ep: 1'b0, buf_sel: ucrh_pkg::BUF_OUT,
									dir_in: 1'b0, len: len17,
									cfg: (state_q == ucrh_pkg::ST_CONFIGURED)};
								n       = 2'd1;
							end
						end
						default: begin
							cmds[0] = '{valid: 1'b1, ep: 1'b0, buf_sel: ucrh_pkg::BUF_OUT,
								dir_in: 1'b0, len: len17, cfg: 1'b0};
							cmds[1] = c_ack;
							cmds[2] = '{valid: 1'b1, ep: 1'b1, buf_sel: ucrh_pkg::BUF_OUT,
								dir_in: 1'b0, len: ucrh_pkg::LEN_EP1_OUT, cfg: 1'b0};
							n       = 2'd3;
							op_d    = ucrh_pkg::OP_RECEIVE;
						end
					endcase
				end else if (rtype == ucrh_pkg::RTYPE_CLASS) begin
					if (request_code == ucrh_pkg::REQ_SET_IDLE) begin
						cmds[0] = c_ack;
						n       = 2'd1;
					end else if (request_code == ucrh_pkg::REQ_SET_REPORT) begin
						cmds[0] = '{valid: 1'b1, ep: 1'b0, buf_sel: ucrh_pkg::BUF_OUT,
							dir_in: 1'b0, len: len17 + ucrh_pkg::LEN_REPORT_HDR, cfg: 1'b0};
						n       = 2'd1;
						rl_d    = request_length;
						op_d    = ucrh_pkg::OP_RECEIVE;
					end
				end
			end
			ucrh_pkg::KIND_BUS_RST: begin
				state_d = ucrh_pkg::ST_DEFAULT;
			end
			ucrh_pkg::KIND_CONSUMED: begin
				if (op_q == ucrh_pkg::OP_RECEIVE) begin
					consumed = 1'b1;
					rl_d     = 16'd0;
					op_d     = ucrh_pkg::OP_NONE;
					cmds[0]  = c_ack;
					n        = 2'd1;
				end
			end
			default: begin
			end
		endcase
		// A request that queues no transfer still yields one status result.
		if (n == 2'd0) begin
			n = 2'd1;
		end
		job.n     = n;
		job.cmd   = cmds;
		job.state = state_d;
		job.addr  = addr_d;
		job.op    = op_d;
		job.rep   = consumed ? rl_q : rl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucrh_pkg::ST_ATTACHED;
			addr_q  <= 7'd0;
			op_q    <= ucrh_pkg::OP_NONE;
			rl_q    <= 16'd0;
		end else if (push) begin
			state_q <= state_d;
			addr_q  <= addr_d;
			op_q    <= op_d;
			rl_q    <= rl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_len_q    <= ucrh_pkg::RST_DEV_LEN;
			str0_len_q   <= ucrh_pkg::RST_STR0_LEN;
			man_len_q    <= ucrh_pkg::RST_MAN_LEN;
			prod_len_q   <= ucrh_pkg::RST_PROD_LEN;
			report_len_q <= ucrh_pkg::RST_REPORT_LEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ucrh_pkg::REG_DEV_LEN:    dev_len_q    <= cfg_data[7:0];
				ucrh_pkg::REG_STR0_LEN:   str0_len_q   <= cfg_data[7:0];
				ucrh_pkg::REG_MAN_LEN:    man_len_q    <= cfg_data[7:0];
				ucrh_pkg::REG_PROD_LEN:   prod_len_q   <= cfg_data[7:0];
				ucrh_pkg::REG_REPORT_LEN: report_len_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: src/ucrh_queue.sv
// Short request queue between the front and back ends of the handler.
// Register array with wrapping pointers and an occupancy count.
// Depends on ucrh_pkg for the request record type.
module ucrh_queue #(
	parameter int DEPTH = ucrh_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ucrh_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output ucrh_pkg::job_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ucrh_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy above depth");

endmodule

FILE: src/ucrh_back.sv
// Back end of the handler: steps through the commands of the request at the
// head of the queue, one result per cycle while the output is not stalled,
// into a registered output stage. Depends on ucrh_pkg.
module ucrh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  ucrh_pkg::job_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output ucrh_pkg::res_t res
);

	logic [1:0]     k_q;
	logic           out_valid_q;
	ucrh_pkg::res_t res_q;
	ucrh_pkg::cmd_t cur;
	logic           load, is_last;

	assign cur     = head.cmd[k_q];
	assign is_last = (k_q == head.n - 2'd1);
	assign load    = !empty && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				k_q         <= is_last ? 2'd0 : k_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.cmd      <= cur;
			res_q.too_long <= (cur.len > ucrh_pkg::MAX_TRANSFER);
			res_q.state    <= head.state;
			res_q.addr     <= head.addr;
			res_q.op       <= head.op;
			res_q.rep      <= head.rep;
			res_q.last     <= is_last;
		end
	end

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.cmd.valid |-> res_q.last)
		else $error("status result not marked last");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (k_q < head.n))
		else $error("command index past end of request");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && res_q.last && k_q == 2'd0))
		else $error("request released before its last result");

endmodule

FILE: src/usb_control_request_handler_top.sv
// An accepted request is written into the queue on the accepting edge; its first result is then
// loaded into the output register. Throughput: one result per cycle while the output is not
// stalled, one per command; a request yields one to three results.
// Requests are accepted back to back until the queue fills, as it can when results back up.
// Reset is asynchronous and active low: device state attached, address zero, no pending
// operation, report length zero, registers at their default descriptor lengths.
module usb_control_request_handler_top #(
	parameter int QUEUE_DEPTH = ucrh_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  event_kind,
	input  logic [7:0]  request_type_byte,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] request_index,
	input  logic [15:0] request_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        transfer_valid,
	output logic        endpoint_number,
	output logic [2:0]  buffer_select,
	output logic        direction_in,
	output logic [16:0] transfer_length,
	output logic        too_long,
	output logic [2:0]  state_now,
	output logic [6:0]  address_now,
	output logic [1:0]  pending_op,
	output logic [15:0] report_bytes,
	output logic        config_value,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	ucrh_pkg::job_t push_job, head;
	ucrh_pkg::res_t res;
	logic           push, pop, q_full, q_empty;

	ucrh_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.event_kind        (event_kind),
		.request_type_byte (request_type_byte),
		.request_code      (request_code),
		.request_value     (request_value),
		.request_index     (request_index),
		.request_length    (request_length),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.q_full            (q_full),
		.push              (push),
		.job               (push_job)
	);

	ucrh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	ucrh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign transfer_valid  = res.cmd.valid;
	assign endpoint_number = res.cmd.ep;
	assign buffer_select   = res.cmd.buf_sel;
	assign direction_in    = res.cmd.dir_in;
	assign transfer_length = res.cmd.len;
	assign too_long        = res.too_long;
	assign state_now       = res.state;
	assign address_now     = res.addr;
	assign pending_op      = res.op;
	assign report_bytes    = res.rep;
	assign config_value    = res.cmd.cfg;
	assign last            = res.last;

endmodule
